// ===== sv/bdpc_pkg.sv =====
// Package: payload structs, event codes, register indexes and state type.
package bdpc_pkg;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SHORT  = 2'd1,
    KIND_LONG   = 2'd2,
    KIND_REPEAT = 2'd3
  } bdpc_kind_e;

  typedef enum logic {
    REG_DEBOUNCE_MS   = 1'b0,
    REG_LONG_PRESS_MS = 1'b1
  } bdpc_reg_e;

  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd20;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1000;

  typedef struct packed {
    logic        raw_pressed;
    logic [31:0] now_ms;
  } bdpc_in_t;

  typedef struct packed {
    bdpc_kind_e event_kind;
    logic       pressed_now;
    logic       long_enough;
  } bdpc_out_t;

  typedef struct packed {
    logic        raw_level;
    logic [31:0] raw_change_time;
    logic [31:0] event_time;
    logic        stable_level;
    logic        held_flag;
  } bdpc_state_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
  } bdpc_cfg_t;

endpackage

// ===== sv/bdpc_step.sv =====
// Next-state and result logic for one poll of the debouncer.
module bdpc_step import bdpc_pkg::*; (
  input  bdpc_cfg_t   cfg_i,
  input  bdpc_state_t state_i,
  input  bdpc_in_t    item_i,
  output bdpc_state_t state_o,
  output bdpc_out_t   result_o
);

  logic        lvl;
  logic [31:0] now;
  logic        raw_chg;
  logic [31:0] raw_diff;
  logic        flip;
  logic        stable1;
  logic [31:0] evt_diff;
  logic        lp_zero;
  logic        evt_ge;
  logic        short_hit;
  logic        evt_upd1;
  logic        held1;
  logic        ge1;
  logic        long_hit;
  logic        evt_upd;
  logic        ge2;

  assign lvl      = item_i.raw_pressed;
  assign now      = item_i.now_ms;
  assign raw_chg  = (lvl != state_i.raw_level);
  // A raw change restarts the timer, so the elapsed time is zero then.
  assign raw_diff = raw_chg ? 32'd0 : (now - state_i.raw_change_time);
  assign flip     = (raw_diff > {16'd0, cfg_i.debounce_ms}) && (lvl != state_i.stable_level);
  assign stable1  = flip ? lvl : state_i.stable_level;

  assign evt_diff = now - state_i.event_time;
  assign lp_zero  = (cfg_i.long_press_ms == 16'd0);
  assign evt_ge   = (evt_diff >= {16'd0, cfg_i.long_press_ms});

  assign short_hit = flip && !lvl && !state_i.held_flag && !evt_ge;
  assign evt_upd1  = (flip && lvl) || short_hit;
  assign held1     = (flip && !lvl) ? 1'b0 : state_i.held_flag;
  // Once the event time moves to now, the elapsed time is zero.
  assign ge1       = evt_upd1 ? lp_zero : evt_ge;
  assign long_hit  = stable1 && ge1;
  assign evt_upd   = evt_upd1 || long_hit;
  assign ge2       = evt_upd ? lp_zero : evt_ge;

  always_comb begin
    state_o.raw_level       = lvl;
    state_o.raw_change_time = raw_chg ? now : state_i.raw_change_time;
    state_o.event_time      = evt_upd ? now : state_i.event_time;
    state_o.stable_level    = stable1;
    state_o.held_flag       = long_hit ? 1'b1 : held1;

    priority if (long_hit) begin
      result_o.event_kind = held1 ? KIND_REPEAT : KIND_LONG;
    end else if (short_hit) begin
      result_o.event_kind = KIND_SHORT;
    end else begin
      result_o.event_kind = KIND_NONE;
    end
    result_o.pressed_now = stable1;
    result_o.long_enough = stable1 && (state_o.held_flag || ge2);
  end

endmodule

// ===== sv/button_debounce_press_classifier_unit.sv =====
// Top level: button debouncer with short, long and repeat press classification.
// Path: a poll is captured in the input register, then its result is registered.
// Throughput: one poll per cycle unless the result stalls; the state update
//   is a single pass of subtract and compare logic between input and result registers.
// Reset: debounce 20 ms, long press 1000 ms, all timestamps and levels zero,
//   both pipeline registers empty.
module button_debounce_press_classifier_unit import bdpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  bdpc_reg_e   cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  bdpc_in_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output bdpc_out_t   out_item_o
);

  // Configuration registers.
  bdpc_cfg_t   cfg_q;

  // Input register stage.
  logic        in_valid_q;
  bdpc_in_t    in_item_q;

  // Debouncer state, advanced once per poll leaving the input stage.
  bdpc_state_t state_q, state_d;

  // Result register.
  logic        out_valid_q;
  bdpc_out_t   out_item_q, result_d;

  logic        out_free;
  logic        step_go;
  logic        in_take;

  // Result register can load when empty or when its transfer completes now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_go    = in_valid_q && out_free;
  // Hold the input stage while its poll cannot move on.
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DEBOUNCE_MS_RST;
      cfg_q.long_press_ms <= LONG_PRESS_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_data_i;
        REG_LONG_PRESS_MS: cfg_q.long_press_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bdpc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Input stage: load on a transfer, drop when its poll advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
  end

  // State and result advance together when the poll leaves the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      out_item_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A short press is only ever reported on a release.
  a_short_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_item_q.event_kind == KIND_SHORT) |-> !out_item_q.pressed_now)
    else $error("short press reported while pressed");

  // Long and repeat events need the button held long enough.
  a_long_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ((out_item_q.event_kind == KIND_LONG) ||
                    (out_item_q.event_kind == KIND_REPEAT))
    |-> (out_item_q.pressed_now && out_item_q.long_enough))
    else $error("long or repeat event without a held press");

  // The held flag is cleared on every debounced release.
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.held_flag |-> state_q.stable_level)
    else $error("held flag set while released");

  // A stalled result keeps the stage behind it from advancing.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_item_q))
    else $error("stalled result overwritten");

endmodule
